// ----- sv/u8dc_pkg.sv -----
// ----------------------------------------------------------------------------
// u8dc_pkg
// Shared types, class codes and lookup functions of the UTF-8 decoder with
// lexer character classification.
// ----------------------------------------------------------------------------
package u8dc_pkg;

    localparam int ROW_BITS = 24;
    localparam int ROW_OUT_BITS = 24;
    localparam int POINT_BITS = 21;
    localparam int CLASS_BITS = 6;

    localparam logic [CLASS_BITS-1:0] CLS_BREAK  = 6'd0;
    localparam logic [CLASS_BITS-1:0] CLS_SPACE  = 6'd1;
    localparam logic [CLASS_BITS-1:0] CLS_PUNCT0 = 6'd2;
    localparam logic [CLASS_BITS-1:0] CLS_DIGIT  = 6'd34;
    localparam logic [CLASS_BITS-1:0] CLS_UPPER  = 6'd35;
    localparam logic [CLASS_BITS-1:0] CLS_LOWER  = 6'd36;
    localparam logic [CLASS_BITS-1:0] CLS_OTHER  = 6'd37;
    localparam logic [CLASS_BITS-1:0] CLS_ERROR  = 6'd38;
    localparam logic [CLASS_BITS-1:0] CLS_EOF    = 6'd39;

    localparam logic [POINT_BITS-1:0] WHITE_VALUE = 21'h20;
    localparam logic [POINT_BITS-1:0] CP_LF  = 21'h0A;
    localparam logic [POINT_BITS-1:0] CP_CR  = 21'h0D;
    localparam logic [POINT_BITS-1:0] CP_TAB = 21'h09;
    localparam logic [POINT_BITS-1:0] CP_SP  = 21'h20;

    localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};

    typedef logic [ROW_BITS-1:0] t_row;
    typedef logic [1:0] t_pending;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [CLASS_BITS-1:0]   char_class;
        logic [POINT_BITS-1:0]   code_point;
        logic [ROW_OUT_BITS-1:0] row_number;
    } t_out;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_ERROR,
        KIND_EOF
    } t_kind;

    typedef struct packed {
        logic                  emit;
        t_kind                 kind;
        logic [POINT_BITS-1:0] cp;
    } t_dec;

    // Returns the punctuation class of an ASCII code, or CLS_OTHER if none.
    function automatic logic [CLASS_BITS-1:0] punct_class(input logic [6:0] c);
        logic [CLASS_BITS-1:0] r;
        case (c)
            7'h21: r = 6'd2;
            7'h22: r = 6'd3;
            7'h23: r = 6'd4;
            7'h24: r = 6'd5;
            7'h25: r = 6'd6;
            7'h26: r = 6'd7;
            7'h27: r = 6'd8;
            7'h28: r = 6'd9;
            7'h29: r = 6'd10;
            7'h2A: r = 6'd11;
            7'h2B: r = 6'd12;
            7'h2C: r = 6'd13;
            7'h2D: r = 6'd14;
            7'h2E: r = 6'd15;
            7'h2F: r = 6'd16;
            7'h3A: r = 6'd17;
            7'h3B: r = 6'd18;
            7'h3C: r = 6'd19;
            7'h3D: r = 6'd20;
            7'h3E: r = 6'd21;
            7'h3F: r = 6'd22;
            7'h40: r = 6'd23;
            7'h5B: r = 6'd24;
            7'h5D: r = 6'd25;
            7'h5C: r = 6'd26;
            7'h5E: r = 6'd27;
            7'h5F: r = 6'd28;
            7'h60: r = 6'd29;
            7'h7B: r = 6'd30;
            7'h7D: r = 6'd31;
            7'h7C: r = 6'd32;
            7'h7E: r = 6'd33;
            default: r = CLS_OTHER;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/u8dc_decode.sv -----
// ----------------------------------------------------------------------------
// u8dc_decode
// UTF-8 sequence assembly: holds the pending byte count and the partial code
// point, and reports a finished character, an error or an end mark.
// ----------------------------------------------------------------------------
module u8dc_decode
    import u8dc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_advance,
    input  t_in  i_req,
    output t_dec o_dec
);

    t_pending              r_pending, n_pending;
    logic [POINT_BITS-1:0] r_partial, n_partial;
    logic [POINT_BITS-1:0] w_shifted;
    logic [7:0]            w_b;
    logic                  w_cont;

    assign w_b       = i_req.byte_in;
    assign w_cont    = (w_b[7:6] == 2'b10);
    assign w_shifted = {r_partial[POINT_BITS-7:0], w_b[5:0]};

    always_comb begin
        n_pending  = r_pending;
        n_partial  = r_partial;
        o_dec.emit = 1'b0;
        o_dec.kind = KIND_CHAR;
        o_dec.cp   = '0;
        if (i_req.end_of_input) begin
            o_dec.emit = 1'b1;
            if (r_pending != 2'd0) begin
                o_dec.kind = KIND_ERROR;
                n_pending  = 2'd0;
                n_partial  = '0;
            end else begin
                o_dec.kind = KIND_EOF;
            end
        end else if (r_pending != 2'd0) begin
            if (!w_cont) begin
                o_dec.emit = 1'b1;
                o_dec.kind = KIND_ERROR;
                n_pending  = 2'd0;
                n_partial  = '0;
            end else if (r_pending == 2'd1) begin
                o_dec.emit = 1'b1;
                o_dec.cp   = w_shifted;
                n_pending  = 2'd0;
                n_partial  = '0;
            end else begin
                n_pending = r_pending - 2'd1;
                n_partial = w_shifted;
            end
        end else if (!w_b[7]) begin
            o_dec.emit = 1'b1;
            o_dec.cp   = POINT_BITS'(w_b);
        end else if (w_b[7:6] == 2'b10) begin
            o_dec.emit = 1'b1;
            o_dec.kind = KIND_ERROR;
        end else if (w_b[7:5] == 3'b110) begin
            n_pending = 2'd1;
            n_partial = POINT_BITS'(w_b[4:0]);
        end else if (w_b[7:4] == 4'b1110) begin
            n_pending = 2'd2;
            n_partial = POINT_BITS'(w_b[3:0]);
        end else if (w_b[7:3] == 5'b11110) begin
            n_pending = 2'd3;
            n_partial = POINT_BITS'(w_b[2:0]);
        end else begin
            o_dec.emit = 1'b1;
            o_dec.kind = KIND_ERROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
        end else if (i_advance) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

endmodule

// ----- sv/u8dc_classify.sv -----
// ----------------------------------------------------------------------------
// u8dc_classify
// Lexer classification of a decoded character and the saturating line
// counter that a line-feed advances.
// ----------------------------------------------------------------------------
module u8dc_classify
    import u8dc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_advance,
    input  t_dec i_dec,
    output t_out o_res
);

    t_row r_line, n_line;
    logic w_lf;

    assign w_lf = i_dec.emit && (i_dec.kind == KIND_CHAR) && (i_dec.cp == CP_LF);

    always_comb begin
        n_line = r_line;
        if (w_lf && (r_line != ROW_MAX)) begin
            n_line = r_line + t_row'(1);
        end
    end

    always_comb begin
        o_res.row_number = ROW_OUT_BITS'(n_line);
        o_res.code_point = i_dec.cp;
        o_res.char_class = CLS_OTHER;
        case (i_dec.kind)
            KIND_ERROR: begin
                o_res.char_class = CLS_ERROR;
                o_res.code_point = '0;
            end
            KIND_EOF: begin
                o_res.char_class = CLS_EOF;
                o_res.code_point = '0;
            end
            KIND_CHAR: begin
                if (i_dec.cp == CP_LF || i_dec.cp == CP_CR) begin
                    o_res.char_class = CLS_BREAK;
                    o_res.code_point = WHITE_VALUE;
                end else if (i_dec.cp == CP_TAB || i_dec.cp == CP_SP) begin
                    o_res.char_class = CLS_SPACE;
                    o_res.code_point = WHITE_VALUE;
                end else if (i_dec.cp[POINT_BITS-1:7] != '0) begin
                    o_res.char_class = CLS_OTHER;
                end else if (i_dec.cp[6:0] >= 7'h30 && i_dec.cp[6:0] <= 7'h39) begin
                    o_res.char_class = CLS_DIGIT;
                end else if (i_dec.cp[6:0] >= 7'h41 && i_dec.cp[6:0] <= 7'h5A) begin
                    o_res.char_class = CLS_UPPER;
                end else if (i_dec.cp[6:0] >= 7'h61 && i_dec.cp[6:0] <= 7'h7A) begin
                    o_res.char_class = CLS_LOWER;
                end else begin
                    o_res.char_class = punct_class(i_dec.cp[6:0]);
                end
            end
            default: begin
                o_res.char_class = CLS_ERROR;
                o_res.code_point = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else if (i_advance && i_dec.emit) begin
            r_line <= n_line;
        end
    end

endmodule

// ----- sv/utf8_decode_char_classify_top.sv -----
// ----------------------------------------------------------------------------
// utf8_decode_char_classify_top
// UTF-8 byte stream decoder with lexer character classification.
// ----------------------------------------------------------------------------
// The input channel carries one request per byte: the raw byte and an end
// mark. The output channel carries the class, code point and row number of
// each finished character, error or end mark. Both channels use valid and
// ready handshakes.
// A request is captured in an input register; from there it is decoded and
// classified, and its result is loaded into the output register. Lead bytes
// and inner continuation bytes of a sequence give no result.
// One request is accepted every cycle while the output side keeps up; the
// rate is set by the combinational decode path between the two registers.
// When the receiver stalls, the output register holds its result, the input
// register holds one more request, and then input ready falls.
// Reset clears the decoder to idle, the partial code point and the row
// counter to zero, and empties both registers.
// ----------------------------------------------------------------------------
module utf8_decode_char_classify_top
    import u8dc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_res
);

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    logic w_advance;
    t_dec w_dec;
    t_out w_res;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    u8dc_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_req     (r_in),
        .o_dec     (w_dec)
    );

    u8dc_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_dec     (w_dec),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_dec.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_dec.emit) begin
            r_out <= w_res;
        end
    end

endmodule

// ----- tb/utf8_class_checker.sv -----
// ----------------------------------------------------------------------------
// utf8_class_checker
// Watches both channels of the UTF-8 decoder, predicts the class, code point
// and row of every finished character and compares them with the results.
// ----------------------------------------------------------------------------
module utf8_class_checker
    import u8dc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_req,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_res,
    output int   o_fail_count,
    output int   o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // The 32 punctuation marks in class order, first mark in the top byte.
    localparam logic [255:0] MARK_CODES = {
        8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
        8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h3A,
        8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5D,
        8'h5C, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7C, 8'h7E
    };

    t_pending              seq_left;
    logic [POINT_BITS-1:0] seq_bits;
    t_row                  line_total;
    t_out                  expected_chars[$];
    int                    fails = 0;

    function automatic t_out marker_result(input logic [CLASS_BITS-1:0] cls);
        t_out r;
        r.char_class = cls;
        r.code_point = '0;
        r.row_number = ROW_OUT_BITS'(line_total);
        return r;
    endfunction

    function automatic t_out classify_point(input logic [POINT_BITS-1:0] cp);
        t_out r;
        int   i;
        r.char_class = CLS_OTHER;
        r.code_point = cp;
        if (cp == CP_LF) begin
            if (line_total != ROW_MAX) begin
                line_total = line_total + t_row'(1);
            end
            r.char_class = CLS_BREAK;
            r.code_point = WHITE_VALUE;
        end else if (cp == CP_CR) begin
            r.char_class = CLS_BREAK;
            r.code_point = WHITE_VALUE;
        end else if (cp == CP_TAB || cp == CP_SP) begin
            r.char_class = CLS_SPACE;
            r.code_point = WHITE_VALUE;
        end else if (cp >= 21'h30 && cp <= 21'h39) begin
            r.char_class = CLS_DIGIT;
        end else if (cp >= 21'h41 && cp <= 21'h5A) begin
            r.char_class = CLS_UPPER;
        end else if (cp >= 21'h61 && cp <= 21'h7A) begin
            r.char_class = CLS_LOWER;
        end else begin
            for (i = 0; i < 32; i++) begin
                if (cp == {13'd0, MARK_CODES[8*(31-i) +: 8]}) begin
                    r.char_class = CLS_PUNCT0 + 6'(i);
                end
            end
        end
        r.row_number = ROW_OUT_BITS'(line_total);
        return r;
    endfunction

    // Advances the decoder by one byte; returns 1 when a result is due.
    function automatic bit decode_byte(input t_in req, output t_out res);
        logic [7:0] b;
        b = req.byte_in;
        res = '0;
        if (req.end_of_input) begin
            res = marker_result((seq_left != 0) ? CLS_ERROR : CLS_EOF);
            seq_left = '0;
            seq_bits = '0;
            return 1'b1;
        end
        if (seq_left != 0) begin
            if (b[7:6] != 2'b10) begin
                seq_left = '0;
                seq_bits = '0;
                res = marker_result(CLS_ERROR);
                return 1'b1;
            end
            seq_bits = {seq_bits[POINT_BITS-7:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left != 0) begin
                return 1'b0;
            end
            res = classify_point(seq_bits);
            seq_bits = '0;
            return 1'b1;
        end
        if (b < 8'h80) begin
            res = classify_point({13'd0, b});
            return 1'b1;
        end
        if (b < 8'hC0 || b >= 8'hF8) begin
            res = marker_result(CLS_ERROR);
            return 1'b1;
        end
        if (b < 8'hE0) begin
            seq_bits = {16'd0, b[4:0]};
            seq_left = 2'd1;
        end else if (b < 8'hF0) begin
            seq_bits = {17'd0, b[3:0]};
            seq_left = 2'd2;
        end else begin
            seq_bits = {18'd0, b[2:0]};
            seq_left = 2'd3;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        t_out fresh;
        if (!i_rst_n) begin
            seq_left = '0;
            seq_bits = '0;
            line_total = '0;
            expected_chars.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("result with no request waiting",
                                    32'(i_out_res.code_point), 32'd0);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_res.char_class != want.char_class) begin
                        report_mismatch("char_class", 32'(i_out_res.char_class),
                                        32'(want.char_class));
                    end
                    if (i_out_res.code_point != want.code_point) begin
                        report_mismatch("code_point", 32'(i_out_res.code_point),
                                        32'(want.code_point));
                    end
                    if (i_out_res.row_number != want.row_number) begin
                        report_mismatch("row_number", 32'(i_out_res.row_number),
                                        32'(want.row_number));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (decode_byte(i_in_req, fresh)) begin
                    expected_chars = {expected_chars, fresh};
                end
            end
        end
        o_waiting <= expected_chars.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/tb_utf8_decode_char_classify_top.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_decode_char_classify_top
// Drives byte requests into the UTF-8 decoder and gives the final verdict.
// ----------------------------------------------------------------------------
// A directed run covers all class kinds but digits, the widest code points and
// each error path; a random run then mixes well-formed sequences with broken
// ones, stray bytes and end marks, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_utf8_decode_char_classify_top;
    import u8dc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 750;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_req = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_res;

    int   fail_count;
    int   waiting;
    int   idle_cycles = 0;
    int   rx_cycle = 0;
    int   hold_left = 0;
    int   hold_asks = 0;
    int   holds_done = 0;
    int   burst_left = 0;
    int   sent = 0;
    t_in  byte_run[$];

    utf8_decode_char_classify_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    utf8_class_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_res    (o_out_res),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver cycles through its own stall patterns, and on request holds
    // off for a long stretch so that the decoder fills and stops its input.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_asks) begin
            holds_done <= hold_asks;
            hold_left <= HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_cycle[8:7])
                2'd0: i_out_ready <= 1'b1;
                2'd1: i_out_ready <= 1'($urandom_range(0, 1));
                2'd2: i_out_ready <= (rx_cycle[2:0] != 3'd0);
                default: i_out_ready <= rx_cycle[4];
            endcase
        end
    end

    function automatic void add_byte(input logic [7:0] b, input logic eoi);
        t_in item;
        item.byte_in = b;
        item.end_of_input = eoi;
        byte_run = {byte_run, item};
    endfunction

    function automatic logic [7:0] lead_byte(input int extra);
        if (extra == 1) begin
            return 8'hC0 | 8'($urandom_range(0, 31));
        end else if (extra == 2) begin
            return 8'hE0 | 8'($urandom_range(0, 15));
        end
        return 8'hF0 | 8'($urandom_range(0, 7));
    endfunction

    function automatic void add_random_token();
        int         pick;
        int         extra;
        int         k;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            b = ($urandom_range(0, 9) == 0) ? 8'h0A : 8'($urandom_range(0, 127));
            add_byte(b, 1'b0);
        end else if (pick < 73) begin
            extra = (pick < 53) ? 1 : (pick < 63) ? 2 : 3;
            add_byte(lead_byte(extra), 1'b0);
            for (k = 0; k < extra; k++) begin
                add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
            end
        end else if (pick < 82) begin
            // A sequence cut short by a foreign byte or by the end mark.
            extra = $urandom_range(1, 3);
            add_byte(lead_byte(extra), 1'b0);
            for (k = $urandom_range(0, extra - 1); k > 0; k--) begin
                add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
            end
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10) begin
                b[6] = 1'b1;
            end
            add_byte(b, 1'($urandom_range(0, 2) == 0));
        end else if (pick < 88) begin
            add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        end else if (pick < 92) begin
            add_byte(8'hF8 | 8'($urandom_range(0, 7)), 1'b0);
        end else if (pick < 96) begin
            add_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endfunction

    task automatic send_request(input t_in req);
        i_in_valid <= 1'b1;
        i_in_req <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    // Sends every queued byte in bursts; some stretches run with no gaps.
    task automatic send_run();
        int gap;
        while (byte_run.size() != 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = (((sent / 120) % 3) == 1) ? 0 : $urandom_range(0, 6);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            send_request(byte_run.pop_front());
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    initial begin
        bit mid_drain;
        mid_drain = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_byte(8'h41, 1'b0);
        add_byte(8'h7A, 1'b0);
        add_byte(8'h21, 1'b0);
        add_byte(8'h0A, 1'b0);
        add_byte(8'h0D, 1'b0);
        add_byte(8'h09, 1'b0);
        add_byte(8'h20, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hF8, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b0);
        add_byte(8'hF7, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b1);
        send_run();
        drain_results();

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            add_random_token();
            send_run();
            if (sent >= 250 && hold_asks == 0) begin
                hold_asks <= 1;
            end
            if (sent >= 500 && !mid_drain) begin
                mid_drain = 1'b1;
                drain_results();
            end
        end
        drain_results();
        repeat (6) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
